// ===== sv/ldd_pkg.sv =====
// Shared types, constants and lookup functions for the LED digit display encoder.
// No dependencies; every other file in sv/ uses this package.
package ldd_pkg;

  localparam int DIGIT_COUNT_DEF  = 3;
  localparam int SEGMENT_LEDS_DEF = 29;
  localparam int RESET_SLOTS_DEF  = 50;

  localparam int OP_W    = 2;
  localparam int DIGIT_W = 2;
  localparam int VALUE_W = 4;
  localparam int GROUP_W = 3;
  localparam int LED_W   = 7;
  localparam int LEVEL_W = 8;
  localparam int DUTY_W  = 8;
  localparam int GRB_W   = 24;
  localparam int TQ_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_RENDER = 2'd0;
  localparam logic [OP_W-1:0] OP_BLANK  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;
  localparam logic [OP_W-1:0] OP_EMIT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SACRIFICE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] PERIOD_RST     = 8'd104;
  localparam logic [CFG_DATA_W-1:0] BRIGHTNESS_RST = 8'd45;

  // per-slot control handed from the sequencer to the slot pipeline
  typedef struct packed {
    logic       go;
    logic       is_data;
    logic [4:0] bit_sel;   // 23 = MSB of green
    logic       fend;
  } emit_ctl_t;

  function automatic logic [31:0] seg_pattern(input logic [VALUE_W-1:0] v);
    logic [31:0] p;
    unique case (v)
      4'd0:    p = 32'h1FFEFFF0;
      4'd1:    p = 32'h1E0000F0;
      4'd2:    p = 32'h01FE0FFF;
      4'd3:    p = 32'h1FE00FFF;
      4'd4:    p = 32'h1E00F0FF;
      4'd5:    p = 32'h1FE0FF0F;
      4'd6:    p = 32'h1FFEFF0F;
      4'd7:    p = 32'h1E000FF0;
      4'd8:    p = 32'h1FFEFFFF;
      4'd9:    p = 32'h1FE0FFFF;
      default: p = 32'h0;
    endcase
    return p;
  endfunction

  // GRB order
  function automatic logic [GRB_W-1:0] palette_grb(input logic [GROUP_W-1:0] g);
    logic [GRB_W-1:0] c;
    unique case (g)
      3'd0:    c = 24'h00FF00;
      3'd1:    c = 24'hFF0000;
      3'd2:    c = 24'h0000FF;
      3'd3:    c = 24'hFFFF00;
      3'd4:    c = 24'h00FFFF;
      3'd5:    c = 24'hFF00FF;
      3'd6:    c = 24'hFFFFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // round(tan(deg) * 65536); angles past 45 clamp to 45
  function automatic logic [TQ_W-1:0] tan_q16(input logic [CFG_DATA_W-1:0] a);
    logic [TQ_W-1:0] t;
    unique case (a)
      8'd0:  t = 17'd0;     8'd1:  t = 17'd1144;  8'd2:  t = 17'd2289;
      8'd3:  t = 17'd3435;  8'd4:  t = 17'd4583;  8'd5:  t = 17'd5734;
      8'd6:  t = 17'd6888;  8'd7:  t = 17'd8047;  8'd8:  t = 17'd9210;
      8'd9:  t = 17'd10380; 8'd10: t = 17'd11556; 8'd11: t = 17'd12739;
      8'd12: t = 17'd13930; 8'd13: t = 17'd15130; 8'd14: t = 17'd16340;
      8'd15: t = 17'd17560; 8'd16: t = 17'd18792; 8'd17: t = 17'd20036;
      8'd18: t = 17'd21294; 8'd19: t = 17'd22566; 8'd20: t = 17'd23853;
      8'd21: t = 17'd25157; 8'd22: t = 17'd26478; 8'd23: t = 17'd27818;
      8'd24: t = 17'd29179; 8'd25: t = 17'd30560; 8'd26: t = 17'd31964;
      8'd27: t = 17'd33392; 8'd28: t = 17'd34846; 8'd29: t = 17'd36327;
      8'd30: t = 17'd37837; 8'd31: t = 17'd39378; 8'd32: t = 17'd40951;
      8'd33: t = 17'd42561; 8'd34: t = 17'd44205; 8'd35: t = 17'd45889;
      8'd36: t = 17'd47615; 8'd37: t = 17'd49385; 8'd38: t = 17'd51202;
      8'd39: t = 17'd53070; 8'd40: t = 17'd54991; 8'd41: t = 17'd56970;
      8'd42: t = 17'd59009; 8'd43: t = 17'd61113; 8'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

  // floor(x / 3) by reciprocal, exact for every 9-bit x
  function automatic logic [DUTY_W-1:0] div3(input logic [8:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd43691;
    return p[24:17];
  endfunction

endpackage

// ===== sv/ldd_if.sv =====
// Valid/ready channel interfaces for the LED digit display encoder.
// Depends on ldd_pkg.
interface ldd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ldd_pkg::OP_W-1:0]      op;
  logic [ldd_pkg::DIGIT_W-1:0]   digit_index;
  logic [ldd_pkg::VALUE_W-1:0]   digit_value;
  logic [ldd_pkg::GROUP_W-1:0]   color_sel;
  logic [ldd_pkg::LED_W-1:0]     led_index;
  logic [ldd_pkg::LEVEL_W-1:0]   red;
  logic [ldd_pkg::LEVEL_W-1:0]   green;
  logic [ldd_pkg::LEVEL_W-1:0]   blue;

  modport source (output valid, op, digit_index, digit_value, color_sel, led_index,
                  red, green, blue, input ready);
  modport sink   (input valid, op, digit_index, digit_value, color_sel, led_index,
                  red, green, blue, output ready);
endinterface

interface ldd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ldd_pkg::DUTY_W-1:0]   duty;
  logic                         frame_end;

  modport source (output valid, duty, frame_end, input ready);
  modport sink   (input valid, duty, frame_end, output ready);
endinterface

// ===== sv/ldd_buf.sv =====
// GRB color buffer: one synchronous memory, one write and one read port.
// Per-entry valid bits make never-written entries read as dark. Depends on ldd_pkg.
module ldd_buf #(
  parameter int DEPTH = 90,
  parameter int AW    = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ldd_pkg::GRB_W-1:0]   wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [ldd_pkg::GRB_W-1:0]   rd_data
);
  import ldd_pkg::*;

  logic [GRB_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [GRB_W-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ===== sv/ldd_slot.sv =====
// Slot pipeline: selects the color byte, scales it by brightness, maps the bit
// to a duty value and queues results in a two-entry output FIFO. Depends on ldd_pkg, ldd_if.
module ldd_slot (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ldd_pkg::emit_ctl_t           em,
  input  logic [ldd_pkg::GRB_W-1:0]    rd_data,
  input  logic [ldd_pkg::TQ_W-1:0]     tq,
  input  logic [ldd_pkg::DUTY_W-1:0]   duty_one,
  input  logic [ldd_pkg::DUTY_W-1:0]   duty_zero,
  output logic                         busy,
  output logic                         full,
  ldd_out_if.source                    out_ch
);
  import ldd_pkg::*;

  emit_ctl_t        s1_r;
  logic             s2_v_r;
  logic             s2_data_r;
  logic             s2_fend_r;
  logic [2:0]       s2_bit_r;
  logic [7:0]       s2_sc_r;

  logic [7:0]       byte_sel;
  logic [24:0]      prod;

  logic [DUTY_W-1:0] q_duty_r [2];
  logic              q_fend_r [2];
  logic              head_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic              push;
  logic              pop;
  logic              tail;
  logic [DUTY_W-1:0] duty_nxt;

  always_comb begin
    unique case (s1_r.bit_sel[4:3])
      2'd2:    byte_sel = rd_data[23:16];
      2'd1:    byte_sel = rd_data[15:8];
      default: byte_sel = rd_data[7:0];
    endcase
  end

  assign prod = 25'(byte_sel) * 25'(tq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_v_r <= 1'b0;
    end else begin
      s1_r   <= em;
      s2_v_r <= s1_r.go;
    end
  end

  always_ff @(posedge clk) begin
    s2_data_r    <= s1_r.is_data;
    s2_fend_r    <= s1_r.fend;
    s2_bit_r     <= s1_r.bit_sel[2:0];
    s2_sc_r      <= prod[23:16];
  end

  always_comb begin
    if (!s2_data_r) begin
      duty_nxt = '0;
    end else if (s2_sc_r[s2_bit_r]) begin
      duty_nxt = duty_one;
    end else begin
      duty_nxt = duty_zero;
    end
  end

  assign push    = s2_v_r;
  assign pop     = out_ch.valid && out_ch.ready;
  assign tail    = head_r ^ cnt_r[0];
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      q_duty_r[tail] <= duty_nxt;
      q_fend_r[tail] <= s2_fend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        head_r <= ~head_r;
      end
    end
  end

  assign out_ch.valid     = cnt_r != 2'd0;
  assign out_ch.duty      = q_duty_r[head_r];
  assign out_ch.frame_end = q_fend_r[head_r];
  assign busy             = s1_r.go || s2_v_r;
  assign full             = cnt_r == 2'd2;

endmodule

// ===== sv/ldd_seq.sv =====
// Sequencer: decodes transactions, sweeps a digit's LEDs into the buffer,
// writes single LEDs and tracks the slot position of the frame. Depends on ldd_pkg, ldd_if.
module ldd_seq #(
  parameter int DIGIT_COUNT  = ldd_pkg::DIGIT_COUNT_DEF,
  parameter int SEGMENT_LEDS = ldd_pkg::SEGMENT_LEDS_DEF,
  parameter int RESET_SLOTS  = ldd_pkg::RESET_SLOTS_DEF,
  parameter int AW           = 7,
  parameter int POS_W        = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        sacr,
  input  logic                        slot_busy,
  input  logic                        slot_full,
  ldd_in_if.sink                      in_ch,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [ldd_pkg::GRB_W-1:0]   wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output ldd_pkg::emit_ctl_t          em
);
  import ldd_pkg::*;

  localparam int LED_DEPTH = DIGIT_COUNT * (SEGMENT_LEDS + 1);
  localparam int ACT_W     = $clog2(LED_DEPTH + 1);
  localparam int IW        = $clog2(SEGMENT_LEDS + 1);
  localparam int DS0       = DIGIT_COUNT * SEGMENT_LEDS * 24;
  localparam int DS1       = DIGIT_COUNT * (SEGMENT_LEDS + 1) * 24;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RENDER = 1'b1;

  logic              state_r, state_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic [31:0]       pat_r, pat_nxt;
  logic [GRB_W-1:0]  color_r, color_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  led_r, led_nxt;
  logic [4:0]        bit_r, bit_nxt;

  logic              fire;
  logic              digit_ok;
  logic              led_ok;
  logic [ACT_W-1:0]  active;
  logic [POS_W-1:0]  data_slots;
  logic [POS_W-1:0]  last_slot;
  logic [IW-1:0]     last_i;
  logic [IW-1:0]     first_i;
  logic              lit;
  logic [AW-1:0]     base;

  assign in_ch.ready = (state_r == ST_IDLE) && !slot_busy && !slot_full;
  assign fire        = in_ch.valid && in_ch.ready;

  assign active     = sacr ? ACT_W'(DIGIT_COUNT * (SEGMENT_LEDS + 1))
                           : ACT_W'(DIGIT_COUNT * SEGMENT_LEDS);
  assign data_slots = sacr ? POS_W'(DS1) : POS_W'(DS0);
  assign last_slot  = data_slots + POS_W'(RESET_SLOTS - 1);
  assign first_i    = IW'(sacr);
  assign last_i     = IW'(SEGMENT_LEDS - 1) + first_i;
  assign digit_ok   = 4'(in_ch.digit_index) < 4'(DIGIT_COUNT);
  assign led_ok     = 9'(in_ch.led_index) < 9'(active);
  assign base       = sacr ? AW'(32'(in_ch.digit_index) * (SEGMENT_LEDS + 1))
                           : AW'(32'(in_ch.digit_index) * SEGMENT_LEDS);
  // the sacrificial LED leads and stays dark
  assign lit        = (i_r >= first_i) && pat_r[0];

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    waddr_nxt = waddr_r;
    pat_nxt   = pat_r;
    color_nxt = color_r;
    wr_en     = 1'b0;
    wr_addr   = waddr_r;
    wr_data   = lit ? color_r : '0;
    unique case (state_r)
      ST_IDLE: begin
        if (fire && (in_ch.op == OP_RENDER || in_ch.op == OP_BLANK) && digit_ok) begin
          state_nxt = ST_RENDER;
          i_nxt     = '0;
          waddr_nxt = base;
          pat_nxt   = (in_ch.op == OP_RENDER) ? seg_pattern(in_ch.digit_value) : '0;
          color_nxt = palette_grb(in_ch.color_sel);
        end else if (fire && in_ch.op == OP_SET && led_ok) begin
          wr_en   = 1'b1;
          wr_addr = AW'(in_ch.led_index);
          wr_data = {in_ch.green, in_ch.red, in_ch.blue};
        end
      end
      ST_RENDER: begin
        wr_en     = 1'b1;
        i_nxt     = i_r + IW'(1);
        waddr_nxt = waddr_r + AW'(1);
        if (i_r >= first_i) begin
          pat_nxt = pat_r >> 1;
        end
        if (i_r == last_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // slot position kept as pos = led * 24 + bit so no divider is needed
  always_comb begin
    pos_nxt     = pos_r;
    led_nxt     = led_r;
    bit_nxt     = bit_r;
    em.go       = fire && (in_ch.op == OP_EMIT);
    em.is_data  = pos_r < data_slots;
    em.bit_sel  = 5'd23 - bit_r;
    em.fend     = !(pos_r < last_slot);
    rd_en       = em.go && em.is_data;
    rd_addr     = led_r[AW-1:0];
    if (em.go) begin
      if (pos_r < last_slot) begin
        pos_nxt = pos_r + POS_W'(1);
        if (bit_r == 5'd23) begin
          bit_nxt = '0;
          led_nxt = led_r + POS_W'(1);
        end else begin
          bit_nxt = bit_r + 5'd1;
        end
      end else begin
        pos_nxt = '0;
        led_nxt = '0;
        bit_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      led_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      led_r   <= led_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    waddr_r <= waddr_nxt;
    pat_r   <= pat_nxt;
    color_r <= color_nxt;
  end

endmodule

// ===== sv/led_digit_display_ws2812_encoder.sv =====
// Top level of the WS2812 encoder for a seven-segment LED digit display.
// Depends on ldd_pkg, ldd_if, ldd_buf, ldd_slot, ldd_seq.
//
// Usage:
//   in_ch (valid/ready) carries one operation per transaction: render a digit,
//   blank a digit, set one LED, or emit the next PWM slot of the frame.
//   out_ch (valid/ready) returns one duty/frame_end result per emit only.
//   cfg_we/cfg_index/cfg_wdata write the PWM period (0), sacrificial_enable (1)
//   and brightness (2); write only while no transaction is in progress.
// Timing:
//   Render and blank occupy the block for a sweep over the digit's stride of LEDs,
//   one buffer write per LED through the single memory write port.
//   Set-one-LED writes the buffer in the cycle it is accepted. Emit runs buffer read,
//   brightness multiply and duty select in turn, then queues its result in the FIFO.
// Reset:
//   rst_n is synchronous. The buffer reads dark right after reset (per-entry
//   valid bits), slot position returns to zero, registers take 104/0/45.
// Stall:
//   A two-entry output FIFO holds results; besides a render or blank sweep, in_ch.ready
//   drops only when the FIFO is full or an emit is still in the pipeline.
module led_digit_display_ws2812_encoder #(
  parameter int DIGIT_COUNT  = ldd_pkg::DIGIT_COUNT_DEF,
  parameter int SEGMENT_LEDS = ldd_pkg::SEGMENT_LEDS_DEF,
  parameter int RESET_SLOTS  = ldd_pkg::RESET_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ldd_in_if.sink                          in_ch,
  ldd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ldd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ldd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ldd_pkg::*;

  localparam int LED_DEPTH = DIGIT_COUNT * (SEGMENT_LEDS + 1);
  localparam int AW        = $clog2(LED_DEPTH);
  localparam int POS_W     = $clog2(LED_DEPTH * 24 + RESET_SLOTS);

  logic [DUTY_W-1:0] duty_one_r;
  logic [DUTY_W-1:0] duty_zero_r;
  logic              sacr_r;
  logic [TQ_W-1:0]   tq_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [GRB_W-1:0]  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [GRB_W-1:0]  rd_data;
  emit_ctl_t         em;
  logic              slot_busy;
  logic              slot_full;

  // duties and brightness gain are resolved once at write time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_one_r  <= div3({PERIOD_RST, 1'b0});
      duty_zero_r <= div3({1'b0, PERIOD_RST});
      sacr_r      <= 1'b0;
      tq_r        <= tan_q16(BRIGHTNESS_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD: begin
          duty_one_r  <= div3({cfg_wdata, 1'b0});
          duty_zero_r <= div3({1'b0, cfg_wdata});
        end
        CFG_SACRIFICE:  sacr_r <= cfg_wdata[0];
        CFG_BRIGHTNESS: tq_r   <= tan_q16(cfg_wdata);
        default: ;
      endcase
    end
  end

  ldd_seq #(
    .DIGIT_COUNT  (DIGIT_COUNT),
    .SEGMENT_LEDS (SEGMENT_LEDS),
    .RESET_SLOTS  (RESET_SLOTS),
    .AW           (AW),
    .POS_W        (POS_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .sacr      (sacr_r),
    .slot_busy (slot_busy),
    .slot_full (slot_full),
    .in_ch     (in_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .em        (em)
  );

  ldd_buf #(
    .DEPTH (LED_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ldd_slot u_slot (
    .clk       (clk),
    .rst_n     (rst_n),
    .em        (em),
    .rd_data   (rd_data),
    .tq        (tq_r),
    .duty_one  (duty_one_r),
    .duty_zero (duty_zero_r),
    .busy      (slot_busy),
    .full      (slot_full),
    .out_ch    (out_ch)
  );

  // an emit in flight must hold off the next transaction
  a_emit_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    em.go |=> !in_ch.ready)
    else $error("transaction accepted while emit in flight");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    em.go |=> ##2 out_ch.valid)
    else $error("emit produced no result");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) < LED_DEPTH))
    else $error("buffer write out of range");

  a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("buffer read and write in the same cycle");

endmodule

// ===== test/led_digit_display_ws2812_encoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for led_digit_display_ws2812_encoder: display ops and slot emits under
// swept register settings, checked against an in-bench model of the GRB buffer and slot walk.
// Depends on ldd_pkg, ldd_if and the encoder RTL.
module led_digit_display_ws2812_encoder_test;
  import ldd_pkg::*;

  localparam int SETTLE_CYCLES = 40;   // longest render plus emit pipeline, with margin
  localparam int STUCK_LIMIT   = 2000;
  localparam int BUF_DEPTH     = DIGIT_COUNT_DEF * (SEGMENT_LEDS_DEF + 1);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DIGIT_W-1:0] digit_index;
    logic [VALUE_W-1:0] digit_value;
    logic [GROUP_W-1:0] color_sel;
    logic [LED_W-1:0]   led_index;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } display_op_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              frame_end;
  } slot_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ldd_in_if  in_ch ();
  ldd_out_if out_ch ();

  led_digit_display_ws2812_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [GRB_W-1:0]      grb_buf [0:BUF_DEPTH-1];
  logic [11:0]           slot_pos;
  logic [CFG_DATA_W-1:0] period_q;
  logic [CFG_DATA_W-1:0] bright_q;
  logic                  sac_q;

  slot_result_t slot_results [$];
  display_op_t  op_backlog [$];
  display_op_t  next_op;
  display_op_t  seen_op;
  slot_result_t wanted;

  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned stall_draw;
  int unsigned stuck_cycles;
  int unsigned mismatch_count = 0;
  int unsigned led_n;
  bit          no_idle = 1'b0;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // color byte times tan(angle) in Q16, angle clamped to 45 degrees
  function automatic logic [LEVEL_W-1:0] scale_level(input logic [LEVEL_W-1:0] c);
    logic [7:0]  deg;
    int unsigned tq;
    deg = (bright_q > 8'd45) ? 8'd45 : bright_q;
    case (deg)
      0: tq = 0;          1: tq = 1144;       2: tq = 2289;       3: tq = 3435;
      4: tq = 4583;       5: tq = 5734;       6: tq = 6888;       7: tq = 8047;
      8: tq = 9210;       9: tq = 10380;      10: tq = 11556;     11: tq = 12739;
      12: tq = 13930;     13: tq = 15130;     14: tq = 16340;     15: tq = 17560;
      16: tq = 18792;     17: tq = 20036;     18: tq = 21294;     19: tq = 22566;
      20: tq = 23853;     21: tq = 25157;     22: tq = 26478;     23: tq = 27818;
      24: tq = 29179;     25: tq = 30560;     26: tq = 31964;     27: tq = 33392;
      28: tq = 34846;     29: tq = 36327;     30: tq = 37837;     31: tq = 39378;
      32: tq = 40951;     33: tq = 42561;     34: tq = 44205;     35: tq = 45889;
      36: tq = 47615;     37: tq = 49385;     38: tq = 51202;     39: tq = 53070;
      40: tq = 54991;     41: tq = 56970;     42: tq = 59009;     43: tq = 61113;
      44: tq = 63287;
      default: tq = 65536;
    endcase
    return 8'((32'(c) * tq) >> 16);
  endfunction

  function automatic void apply_display_op(input display_op_t t);
    int unsigned      stride, base, data_slots, last_slot, pos_bit, i;
    logic [31:0]      mask;
    logic [GRB_W-1:0] color, raw, scaled;
    slot_result_t     r;
    stride = SEGMENT_LEDS_DEF + sac_q;
    case (t.op)
      OP_RENDER, OP_BLANK: begin
        if (t.digit_index < DIGIT_COUNT_DEF) begin
          mask  = '0;
          color = '0;
          if (t.op == OP_RENDER) begin
            case (t.digit_value)
              0: mask = 32'h1FFEFFF0;
              1: mask = 32'h1E0000F0;
              2: mask = 32'h01FE0FFF;
              3: mask = 32'h1FE00FFF;
              4: mask = 32'h1E00F0FF;
              5: mask = 32'h1FE0FF0F;
              6: mask = 32'h1FFEFF0F;
              7: mask = 32'h1E000FF0;
              8: mask = 32'h1FFEFFFF;
              9: mask = 32'h1FE0FFFF;
              default: mask = '0;
            endcase
            // buffer words are G,R,B
            case (t.color_sel)
              0: color = 24'h00FF00;
              1: color = 24'hFF0000;
              2: color = 24'h0000FF;
              3: color = 24'hFFFF00;
              4: color = 24'h00FFFF;
              5: color = 24'hFF00FF;
              6: color = 24'hFFFFFF;
              default: color = '0;
            endcase
          end
          base = t.digit_index * stride;
          // dark sacrificial LED leads the digit when enabled
          for (i = 0; i < stride; i++)
            grb_buf[base + i] = (i >= sac_q) ? (mask[i - sac_q] ? color : '0) : '0;
        end
      end
      OP_SET: begin
        if (t.led_index < DIGIT_COUNT_DEF * stride)
          grb_buf[t.led_index] = {t.green, t.red, t.blue};
      end
      default: begin
        data_slots = DIGIT_COUNT_DEF * stride * 24;
        last_slot  = data_slots + RESET_SLOTS_DEF - 1;
        r = '0;
        if (slot_pos < data_slots) begin
          raw     = grb_buf[slot_pos / 24];
          scaled  = {scale_level(raw[23:16]), scale_level(raw[15:8]), scale_level(raw[7:0])};
          pos_bit = 23 - (slot_pos % 24);
          r.duty  = scaled[pos_bit] ? 8'((32'(period_q) * 2) / 3) : 8'(32'(period_q) / 3);
          slot_pos++;
        end else if (slot_pos < last_slot) begin
          slot_pos++;
        end else begin
          // also catches a position left past the end by a stride change
          r.frame_end = 1'b1;
          slot_pos    = '0;
        end
        slot_results.push_back(r);
      end
    endcase
  endfunction

  function automatic display_op_t op_item(input logic [OP_W-1:0] op,
                                          input int unsigned digit, input int unsigned value,
                                          input int unsigned group, input int unsigned led,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    display_op_t t;
    t.op          = op;
    t.digit_index = DIGIT_W'(digit);
    t.digit_value = VALUE_W'(value);
    t.color_sel   = GROUP_W'(group);
    t.led_index   = LED_W'(led);
    t.red         = r;
    t.green       = g;
    t.blue        = b;
    return t;
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic display_op_t random_op(input int unsigned emit_pct);
    display_op_t t;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < emit_pct) t.op = OP_EMIT;
    else if (pick < 9)                    t.op = OP_SET;
    else if (pick < 17)                   t.op = OP_RENDER;
    else                                  t.op = OP_BLANK;
    t.digit_index = DIGIT_W'(($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2));
    t.digit_value = VALUE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 15)
                                                         : $urandom_range(0, 9));
    t.color_sel   = GROUP_W'(($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6));
    t.led_index   = LED_W'(($urandom_range(0, 9) == 0) ? $urandom_range(90, 127)
                                                       : $urandom_range(0, 89));
    t.red         = rand_level();
    t.green       = rand_level();
    t.blue        = rand_level();
    return t;
  endfunction

  function automatic void queue_mix(input int unsigned n, input int unsigned emit_pct);
    int unsigned k;
    for (k = 0; k < n; k++)
      op_backlog.push_back(random_op(emit_pct));
  endfunction

  task automatic settle();
    while (op_backlog.size() != 0 || in_ch.valid || slot_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] period, input logic sac, input logic [7:0] bright,
                           input int unsigned n);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_index <= CFG_SACRIFICE;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, sac};
    @(posedge clk);
    cfg_index <= CFG_BRIGHTNESS;
    cfg_wdata <= bright;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    no_idle = ($urandom_range(0, 3) == 0);
    queue_mix(n, 60);
  endtask

  // op driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (op_backlog.size() != 0) begin
        next_op = op_backlog.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.op          <= next_op.op;
        in_ch.digit_index <= next_op.digit_index;
        in_ch.digit_value <= next_op.digit_value;
        in_ch.color_sel   <= next_op.color_sel;
        in_ch.led_index   <= next_op.led_index;
        in_ch.red         <= next_op.red;
        in_ch.green       <= next_op.green;
        in_ch.blue        <= next_op.blue;
        send_gap          <= no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_draw = no_idle ? 0 : $urandom_range(0, 4);
      recv_stall   <= stall_draw;
      out_ch.ready <= (stall_draw == 0);
    end else if (recv_stall != 0) begin
      recv_stall   <= recv_stall - 1;
      out_ch.ready <= (recv_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: check results first, then fold in register writes and accepted ops
  always @(posedge clk) begin
    if (!rst_n) begin
      for (led_n = 0; led_n < BUF_DEPTH; led_n++)
        grb_buf[led_n] = '0;
      slot_pos     = '0;
      period_q     = PERIOD_RST;
      sac_q        = 1'b0;
      bright_q     = BRIGHTNESS_RST;
      stuck_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (slot_results.size() == 0) begin
          report_mismatch($sformatf("slot with none pending: duty %0d frame_end %0b",
                                    out_ch.duty, out_ch.frame_end));
        end else begin
          wanted = slot_results.pop_front();
          if (out_ch.duty !== wanted.duty)
            report_mismatch($sformatf("duty %0d, want %0d", out_ch.duty, wanted.duty));
          if (out_ch.frame_end !== wanted.frame_end)
            report_mismatch($sformatf("frame_end %0b, want %0b",
                                      out_ch.frame_end, wanted.frame_end));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD:     period_q = cfg_wdata;
          CFG_SACRIFICE:  sac_q    = cfg_wdata[0];
          CFG_BRIGHTNESS: bright_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_op = {in_ch.op, in_ch.digit_index, in_ch.digit_value, in_ch.color_sel,
                   in_ch.led_index, in_ch.red, in_ch.green, in_ch.blue};
        apply_display_op(seen_op);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned k, ph;
    logic [7:0]  period_pick, bright_pick;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_EMIT;
    in_ch.digit_index = '0;
    in_ch.digit_value = '0;
    in_ch.color_sel   = '0;
    in_ch.led_index   = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PERIOD;
    cfg_wdata         = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: dark buffer, ignored digit and LED indexes, bad value and color, edge LEDs
    op_backlog.push_back(op_item(OP_EMIT, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_RENDER, 0, 8, 6, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_RENDER, 1, 15, 0, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_RENDER, 2, 0, 7, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_RENDER, 3, 1, 1, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_BLANK, 3, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_SET, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    op_backlog.push_back(op_item(OP_SET, 0, 0, 0, 86, 8'h00, 8'hFF, 8'h00));
    op_backlog.push_back(op_item(OP_SET, 0, 0, 0, 87, 8'hFF, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_SET, 0, 0, 0, 127, 8'hFF, 8'hFF, 8'hFF));
    for (k = 0; k < 8; k++)
      op_backlog.push_back(op_item(OP_EMIT, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_RENDER, 2, 9, 3, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_BLANK, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_RENDER, 1, 7, 5, 0, 8'h00, 8'h00, 8'h00));
    op_backlog.push_back(op_item(OP_EMIT, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    settle();
    @(negedge clk);
    queue_mix(120, 60);

    run_phase(8'd255, 1'b1, 8'd45, 120);
    run_phase(8'd0, 1'b0, 8'd0, 80);
    run_phase(8'd1, 1'b1, 8'd44, 80);
    run_phase(8'd2, 1'b0, 8'd255, 80);

    // same period and brightness, stride widened then narrowed under a live position
    period_pick = 8'($urandom_range(0, 255));
    bright_pick = 8'($urandom_range(0, 60));
    run_phase(period_pick, 1'b1, bright_pick, 20);
    run_phase(period_pick, 1'b0, bright_pick, 20);

    for (ph = 0; ph < 4; ph++) begin
      period_pick = 8'($urandom_range(0, 255));
      bright_pick = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(46, 255)
                                                   : $urandom_range(0, 45));
      run_phase(period_pick, 1'($urandom_range(0, 1)), bright_pick, 100);
    end

    settle();
    if (slot_results.size() != 0)
      report_mismatch($sformatf("%0d slots never delivered", slot_results.size()));
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== led_digit_display_ws2812_encoder.f =====
sv/ldd_pkg.sv
sv/ldd_if.sv
sv/ldd_buf.sv
sv/ldd_slot.sv
sv/ldd_seq.sv
sv/led_digit_display_ws2812_encoder.sv
test/led_digit_display_ws2812_encoder_test.sv
